>>> src/cpu_arith_flag_unit_macros.svh
// assertion macros for the arithmetic and flag unit
`ifndef CPU_ARITH_FLAG_UNIT_MACROS_SVH
`define CPU_ARITH_FLAG_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CAFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CAFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cafu_pkg.sv
// types and opcode constants for the arithmetic and flag unit
package cafu_pkg;

  localparam logic [3:0] OP_ADC   = 4'd0;
  localparam logic [3:0] OP_SBC   = 4'd1;
  localparam logic [3:0] OP_CMP   = 4'd2;
  localparam logic [3:0] OP_CPX   = 4'd3;
  localparam logic [3:0] OP_CPY   = 4'd4;
  localparam logic [3:0] OP_INC_M = 4'd5;
  localparam logic [3:0] OP_DEC_M = 4'd6;
  localparam logic [3:0] OP_INC_A = 4'd7;
  localparam logic [3:0] OP_DEC_A = 4'd8;
  localparam logic [3:0] OP_INX   = 4'd9;
  localparam logic [3:0] OP_DEX   = 4'd10;
  localparam logic [3:0] OP_INY   = 4'd11;
  localparam logic [3:0] OP_DEY   = 4'd12;

  localparam logic [7:0] BYTE_ONES = 8'hff;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic       neg_flag;
    logic       ovf_flag;
    logic       zero_flag;
    logic       carry_flag;
    logic       mem_write;
    logic [7:0] mem_data;
  } out_item_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic       n;
    logic       v;
    logic       z;
    logic       c;
  } arch_state_t;

endpackage

>>> src/cafu_exec.sv
// execute logic: one instruction against the register file and flags
module cafu_exec
  import cafu_pkg::*;
(
  input  in_item_t    item,
  input  arch_state_t st,
  output arch_state_t st_nxt,
  output out_item_t   res
);

  logic [7:0] add_m;
  logic [8:0] add_sum;
  logic [7:0] add_r;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] step_src;
  logic       step_up;
  logic [7:0] step_r;
  logic       mem_wr;

  always_comb begin
    add_m   = (item.opcode == OP_SBC) ? ~item.operand : item.operand;
    add_sum = {1'b0, st.acc} + {1'b0, add_m} + {8'd0, st.c};
    add_r   = add_sum[7:0];
  end

  always_comb begin
    unique case (item.opcode)
      OP_CPX:  cmp_reg = st.x;
      OP_CPY:  cmp_reg = st.y;
      default: cmp_reg = st.acc;
    endcase
    cmp_diff = {1'b0, cmp_reg} + {1'b0, ~item.operand} + 9'd1;
  end

  always_comb begin
    unique case (item.opcode)
      OP_INC_M, OP_DEC_M:          step_src = item.operand;
      OP_INX, OP_DEX:              step_src = st.x;
      OP_INY, OP_DEY:              step_src = st.y;
      default:                     step_src = st.acc;
    endcase
    step_up = (item.opcode == OP_INC_M) || (item.opcode == OP_INC_A) ||
              (item.opcode == OP_INX) || (item.opcode == OP_INY);
    step_r  = step_up ? (step_src + 8'd1) : (step_src + BYTE_ONES);
  end

  always_comb begin
    st_nxt = st;
    mem_wr = 1'b0;
    unique case (item.opcode)
      OP_ADC, OP_SBC: begin
        st_nxt.acc = add_r;
        st_nxt.c   = add_sum[8];
        st_nxt.v   = ~(st.acc[7] ^ add_m[7]) & (st.acc[7] ^ add_r[7]);
        st_nxt.n   = add_r[7];
        st_nxt.z   = (add_r == 8'd0);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        st_nxt.c = cmp_diff[8];
        st_nxt.n = cmp_diff[7];
        st_nxt.z = (cmp_diff[7:0] == 8'd0);
      end
      OP_INC_M, OP_DEC_M: begin
        mem_wr   = 1'b1;
        st_nxt.n = step_r[7];
        st_nxt.z = (step_r == 8'd0);
      end
      OP_INC_A, OP_DEC_A: begin
        st_nxt.acc = step_r;
        st_nxt.n   = step_r[7];
        st_nxt.z   = (step_r == 8'd0);
      end
      OP_INX, OP_DEX: begin
        st_nxt.x = step_r;
        st_nxt.n = step_r[7];
        st_nxt.z = (step_r == 8'd0);
      end
      OP_INY, OP_DEY: begin
        st_nxt.y = step_r;
        st_nxt.n = step_r[7];
        st_nxt.z = (step_r == 8'd0);
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  always_comb begin
    res.acc_value  = st_nxt.acc;
    res.x_value    = st_nxt.x;
    res.y_value    = st_nxt.y;
    res.neg_flag   = st_nxt.n;
    res.ovf_flag   = st_nxt.v;
    res.zero_flag  = st_nxt.z;
    res.carry_flag = st_nxt.c;
    res.mem_write  = mem_wr;
    res.mem_data   = mem_wr ? step_r : 8'd0;
  end

endmodule

>>> src/cpu_arith_flag_unit.sv
// Eight-bit arithmetic and flag unit (ADC, SBC, compares, increments and
// decrements) holding A, X, Y and the N, V, Z, C flags. Each item is one
// instruction. It is captured in an input register and executed by short
// 9-bit add paths against the held registers. The outcome then lands in a
// result register, the stage after the input register, which drives
// out_valid. With out_stall low, one item can be taken every cycle. When both
// registers are full and the result is held, in_stall follows out_stall in
// the same cycle. Every item gives exactly one result, in order.
// Memory INC and DEC return the new byte on mem_data with mem_write set;
// unused opcodes leave all state as is. Arithmetic is binary only.
module cpu_arith_flag_unit
  import cafu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        s2_valid_r;
  logic        s2_valid_nxt;
  out_item_t   s2_item_r;
  arch_state_t state_r;
  arch_state_t state_nxt;
  out_item_t   exec_res;
  logic        s2_load;
  logic        s1_fire;
  logic        in_fire;

  cafu_exec u_exec (
    .item   (s1_item_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (exec_res)
  );

  assign s2_load   = !s2_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s2_load;
  assign in_stall  = s1_valid_r && !s2_load;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = s2_valid_r;
  assign out_item  = s2_item_r;

  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);
  assign s2_valid_nxt = s1_fire || (s2_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      s2_item_r <= exec_res;
    end
  end

endmodule

>>> src/cafu_checker.sv
// port checker for the arithmetic and flag unit, bound to the top level
`include "cpu_arith_flag_unit_macros.svh"

module cafu_checker
  import cafu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  out_item_t last_r;
  out_item_t last_nxt;
  logic      out_fire;

  assign out_fire = out_valid && !out_stall;
  assign last_nxt = out_fire ? out_item : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else begin
      last_r <= last_nxt;
    end
  end

  `CAFU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")
  `CAFU_ASSERT_NOW(a_empty_takes, !out_valid, !in_stall, "input stalled with no result waiting")
  `CAFU_ASSERT_NOW(a_data_idle, out_valid && !out_item.mem_write, out_item.mem_data == 8'd0, "write-back byte without mem_write")
  `CAFU_ASSERT_NOW(a_mem_nz, out_valid && out_item.mem_write, (out_item.neg_flag == out_item.mem_data[7]) && (out_item.zero_flag == (out_item.mem_data == 8'd0)), "n or z disagrees with write-back byte")
  `CAFU_ASSERT_NOW(a_mem_keeps, out_valid && out_item.mem_write, (out_item.acc_value == last_r.acc_value) && (out_item.x_value == last_r.x_value) && (out_item.y_value == last_r.y_value) && (out_item.ovf_flag == last_r.ovf_flag) && (out_item.carry_flag == last_r.carry_flag), "memory step changed registers or v/c")

endmodule

bind cpu_arith_flag_unit cafu_checker u_cafu_checker (.*);
